// ===== sv/sprite_2bpp_palette_blitter_macros.svh =====
// Assertion helpers used by the checker file.
`ifndef SPRITE_2BPP_PALETTE_BLITTER_MACROS_SVH
`define SPRITE_2BPP_PALETTE_BLITTER_MACROS_SVH

// Same-cycle implication, masked while reset is high.
`define SPB_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sprite blitter check failed");

// Next-cycle implication, masked while reset is high.
`define SPB_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sprite blitter check failed");

// Next-cycle implication that also holds through reset.
`define SPB_ASSERT_RESET(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("sprite blitter reset check failed");

`endif

// ===== sv/spb_pkg.sv =====
package spb_pkg;

  localparam int VIEW_W_DEF = 240;
  localparam int VIEW_H_DEF = 132;

  localparam int CFG_W  = 24;
  localparam int POS_W  = 11;
  localparam int ADDR_W = 25;
  localparam int PROD_W = 28;
  localparam int LANES  = 4;

  localparam logic [3:0] COLOR_WHITE = 4'hF;
  localparam logic [3:0] COLOR_CLEAR = 4'h0;

  typedef enum logic [2:0] {
    REG_DEST_X        = 3'd0,
    REG_DEST_Y        = 3'd1,
    REG_VIEW_BASE     = 3'd2,
    REG_LINE_STRIDE   = 3'd3,
    REG_ROW_BYTES     = 3'd4,
    REG_PALETTE_SEL   = 3'd5,
    REG_DITHER_ENABLE = 3'd6
  } reg_index_t;

  typedef enum logic [1:0] {
    PIX_CLEAR = 2'd0,
    PIX_LOW   = 2'd1,
    PIX_HIGH  = 2'd2,
    PIX_WHITE = 2'd3
  } pix_code_t;

  // Wall ids beyond the real 18 entries repeat entry 0.
  localparam logic [7:0] PAL_TABLE [32] = '{
    8'he6, 8'he6, 8'he6, 8'h72, 8'h72, 8'h72, 8'h62, 8'h62,
    8'h62, 8'h62, 8'h62, 8'he1, 8'h53, 8'h53, 8'hff, 8'h43,
    8'h43, 8'h63, 8'he6, 8'he6, 8'he6, 8'he6, 8'he6, 8'he6,
    8'he6, 8'he6, 8'he6, 8'he6, 8'he6, 8'he6, 8'he6, 8'he6
  };

  typedef struct packed {
    logic signed [POS_W-1:0] py;
    logic signed [POS_W-1:0] x0;
  } pos_t;

  typedef struct packed {
    logic [3:0] color;
    logic       on;
  } lane_res_t;

  function automatic logic [3:0] pal_color(logic [4:0] sel, pix_code_t code);
    logic [7:0] entry;
    logic [3:0] col;
    entry = PAL_TABLE[sel];
    case (code)
      PIX_LOW:   col = entry[3:0];
      PIX_HIGH:  col = entry[7:4];
      PIX_WHITE: col = COLOR_WHITE;
      default:   col = COLOR_CLEAR;
    endcase
    return col;
  endfunction

endpackage

// ===== sv/spb_lane.sv =====
module spb_lane #(
  parameter int VIEW_W = spb_pkg::VIEW_W_DEF
) (
  input  logic                              clk,
  input  logic                              en,
  input  spb_pkg::pix_code_t                code,
  input  logic [4:0]                        palette_select,
  input  logic signed [spb_pkg::POS_W-1:0]  px,
  input  logic                              row_in,
  input  logic                              py_odd,
  input  logic                              dither_enable,
  output spb_pkg::lane_res_t                res
);
  import spb_pkg::*;

  localparam logic signed [POS_W:0] ViewWs = (POS_W + 1)'(VIEW_W);

  logic [3:0] col;
  logic       col_in;
  logic       dropped;

  assign col     = pal_color(palette_select, code);
  assign col_in  = (px >= 0) && ($signed({px[POS_W-1], px}) < ViewWs);
  // Checkerboard: x + y odd exactly when the low bits differ.
  assign dropped = dither_enable && (px[0] ^ py_odd);

  always_ff @(posedge clk) begin
    if (en) begin
      res.color <= col;
      res.on    <= row_in && (col != COLOR_CLEAR) && col_in && !dropped;
    end
  end

endmodule

// ===== sv/spb_ctrl.sv =====
module spb_ctrl (
  input  logic         clk,
  input  logic         rst,
  input  logic         advance,
  input  logic         last_byte,
  input  logic [5:0]   row_bytes,
  input  logic [9:0]   dest_x,
  input  logic [8:0]   dest_y,
  output spb_pkg::pos_t pos
);
  import spb_pkg::*;

  logic [5:0] column_count;
  logic [7:0] row_count;
  logic [5:0] column_count_next;
  logic [7:0] row_count_next;
  logic [5:0] rb;

  // A row length of zero behaves as one byte per row.
  assign rb = (row_bytes == 6'd0) ? 6'd1 : row_bytes;

  always_comb begin
    column_count_next = column_count + 6'd1;
    row_count_next    = row_count;
    if (last_byte) begin
      column_count_next = 6'd0;
      row_count_next    = 8'd0;
    end else if (({1'b0, column_count} + 7'd1) >= {1'b0, rb}) begin
      column_count_next = 6'd0;
      row_count_next    = row_count + 8'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= 6'd0;
      row_count    <= 8'd0;
    end else if (advance) begin
      column_count <= column_count_next;
      row_count    <= row_count_next;
    end
  end

  assign pos.py = $signed({{2{dest_y[8]}}, dest_y}) + $signed({3'b000, row_count});
  assign pos.x0 = $signed({dest_x[9], dest_x}) + $signed({3'b000, column_count, 2'b00});

endmodule

// ===== sv/sprite_2bpp_palette_blitter.sv =====
// 2-bit-per-pixel sprite blitter with per-wall palette and transparency.
// Input channel: one request per source byte (four pixels, bits 7:6 leftmost),
// raster order, row_bytes bytes per sprite row; last_byte closes the sprite
// and returns the row and column counters to zero.
// Output channel: one request per source byte with the frame buffer row
// address, the x of lane 0, four palette colors and a per-lane write mask.
// Both channels use valid/stall; a request moves when valid is high and
// stall is low. Configuration is a plain write port and must only be
// written while no request is in flight.
// Three register stages, stage 1, stage 2 and the output register, carry
// each byte in that order. Throughput: one byte per clock while the
// receiver does not stall; four pixel lanes work side by side, the row
// multiply sits in its own stage and the base add in the output register.
// When the receiver stalls, the output request holds and the three-deep
// pipeline keeps filling; input stall rises only once every stage is full.
// Reset (synchronous, active high) empties the pipeline, clears the counters
// and returns every config register to its power-on value (row_bytes to 1).
module sprite_2bpp_palette_blitter #(
  parameter int VIEW_W = spb_pkg::VIEW_W_DEF,
  parameter int VIEW_H = spb_pkg::VIEW_H_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_write_en,
  input  logic [2:0]                         cfg_index,
  input  logic [spb_pkg::CFG_W-1:0]          cfg_data,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [7:0]                         source_byte,
  input  logic                               last_byte,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [spb_pkg::ADDR_W-1:0]         row_address,
  output logic signed [spb_pkg::POS_W-1:0]   lane_zero_x,
  output logic [3:0]                         color_lane0,
  output logic [3:0]                         color_lane1,
  output logic [3:0]                         color_lane2,
  output logic [3:0]                         color_lane3,
  output logic [3:0]                         write_mask,
  output logic                               end_of_sprite
);
  import spb_pkg::*;

  localparam logic signed [POS_W:0] ViewHs = (POS_W + 1)'(VIEW_H);

  logic [9:0]  dest_x;
  logic [8:0]  dest_y;
  logic [23:0] view_base;
  logic [15:0] line_stride;
  logic [5:0]  row_bytes;
  logic [4:0]  palette_select;
  logic        dither_enable;

  always_ff @(posedge clk) begin
    if (rst) begin
      dest_x         <= '0;
      dest_y         <= '0;
      view_base      <= '0;
      line_stride    <= '0;
      row_bytes      <= 6'd1;
      palette_select <= '0;
      dither_enable  <= 1'b0;
    end else if (cfg_write_en) begin
      case (reg_index_t'(cfg_index))
        REG_DEST_X:        dest_x         <= cfg_data[9:0];
        REG_DEST_Y:        dest_y         <= cfg_data[8:0];
        REG_VIEW_BASE:     view_base      <= cfg_data[23:0];
        REG_LINE_STRIDE:   line_stride    <= cfg_data[15:0];
        REG_ROW_BYTES:     row_bytes      <= cfg_data[5:0];
        REG_PALETTE_SEL:   palette_select <= cfg_data[4:0];
        REG_DITHER_ENABLE: dither_enable  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Pipeline handshake: each stage loads when empty or when it drains.
  logic s1_valid;
  logic s2_valid;
  logic out_en;
  logic s2_en;
  logic s1_en;
  logic accept;

  assign out_en   = !out_valid || !out_stall;
  assign s2_en    = !s2_valid || out_en;
  assign s1_en    = !s1_valid || s2_en;
  assign in_stall = !s1_en;
  assign accept   = in_valid && s1_en;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (s1_en)  s1_valid  <= in_valid;
      if (s2_en)  s2_valid  <= s1_valid;
      if (out_en) out_valid <= s2_valid;
    end
  end

  pos_t pos;

  spb_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .advance   (accept),
    .last_byte (last_byte),
    .row_bytes (row_bytes),
    .dest_x    (dest_x),
    .dest_y    (dest_y),
    .pos       (pos)
  );

  // Stage 1: position of the byte and its raw pixels.
  logic [7:0] s1_src;
  logic       s1_last;
  pos_t       s1_pos;

  always_ff @(posedge clk) begin
    if (s1_en) begin
      s1_src  <= source_byte;
      s1_last <= last_byte;
      s1_pos  <= pos;
    end
  end

  // Stage 2: lanes resolve colors and masks; row offset multiply.
  logic                          row_in;
  logic signed [PROD_W-1:0]      prod;
  logic [PROD_W-1:0]             s2_prod;
  logic signed [POS_W-1:0]       s2_x0;
  logic                          s2_last;
  lane_res_t                     lane_res [LANES];

  assign row_in = (s1_pos.py >= 0) && ($signed({s1_pos.py[POS_W-1], s1_pos.py}) < ViewHs);
  assign prod   = $signed({{(PROD_W-POS_W){s1_pos.py[POS_W-1]}}, s1_pos.py})
                * $signed({{(PROD_W-16){1'b0}}, line_stride});

  for (genvar p = 0; p < LANES; p++) begin : g_lane
    spb_lane #(
      .VIEW_W (VIEW_W)
    ) u_lane (
      .clk            (clk),
      .en             (s2_en),
      .code           (pix_code_t'(s1_src[7-2*p -: 2])),
      .palette_select (palette_select),
      .px             (s1_pos.x0 + POS_W'(p)),
      .row_in         (row_in),
      .py_odd         (s1_pos.py[0]),
      .dither_enable  (dither_enable),
      .res            (lane_res[p])
    );
  end

  always_ff @(posedge clk) begin
    if (s2_en) begin
      s2_prod <= prod;
      s2_x0   <= s1_pos.x0;
      s2_last <= s1_last;
    end
  end

  // Output register: merge the lanes and add the frame base.
  always_ff @(posedge clk) begin
    if (out_en) begin
      row_address   <= {1'b0, view_base} + s2_prod[ADDR_W-1:0];
      lane_zero_x   <= s2_x0;
      color_lane0   <= lane_res[0].color;
      color_lane1   <= lane_res[1].color;
      color_lane2   <= lane_res[2].color;
      color_lane3   <= lane_res[3].color;
      write_mask    <= {lane_res[3].on, lane_res[2].on, lane_res[1].on, lane_res[0].on};
      end_of_sprite <= s2_last;
    end
  end

endmodule

// ===== sv/spb_checker.sv =====
`include "sprite_2bpp_palette_blitter_macros.svh"

module spb_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              in_stall,
  input logic                              out_valid,
  input logic                              out_stall,
  input logic [spb_pkg::ADDR_W-1:0]        row_address,
  input logic [3:0]                        color_lane0,
  input logic [3:0]                        color_lane1,
  input logic [3:0]                        color_lane2,
  input logic [3:0]                        color_lane3,
  input logic [3:0]                        write_mask
);
  import spb_pkg::*;

  logic [3:0] opaque;

  assign opaque = {color_lane3 != COLOR_CLEAR, color_lane2 != COLOR_CLEAR,
                   color_lane1 != COLOR_CLEAR, color_lane0 != COLOR_CLEAR};

  // The input only backs up when a finished result is waiting on the receiver.
  `SPB_ASSERT_NOW(a_stall_only_when_full, in_stall, out_valid && out_stall)

  // A lane is never written with the transparent color.
  `SPB_ASSERT_NOW(a_mask_opaque, out_valid, (write_mask & ~opaque) == 4'd0)

  // A stalled result stays put.
  `SPB_ASSERT_NEXT(a_out_hold, out_valid && out_stall,
    out_valid && $stable(row_address) && $stable(write_mask))

  // Reset empties the pipeline.
  `SPB_ASSERT_RESET(a_reset_empty, rst, !out_valid && !in_stall)

endmodule

bind sprite_2bpp_palette_blitter spb_checker u_spb_checker (
  .clk         (clk),
  .rst         (rst),
  .in_stall    (in_stall),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .row_address (row_address),
  .color_lane0 (color_lane0),
  .color_lane1 (color_lane1),
  .color_lane2 (color_lane2),
  .color_lane3 (color_lane3),
  .write_mask  (write_mask)
);

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
  import spb_pkg::*;

  localparam int VIEW_W         = VIEW_W_DEF;
  localparam int VIEW_H         = VIEW_H_DEF;
  localparam int DRAIN_CYCLES   = 6;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int ITEMS_PER_MODE = 350;

  // Index 7 has no register behind it; writes to it must be ignored.
  localparam logic [2:0] REG_SPARE = 3'd7;

  localparam logic [7:0] WALL_COLORS [18] = '{
    8'he6, 8'he6, 8'he6, 8'h72, 8'h72, 8'h72, 8'h62, 8'h62, 8'h62,
    8'h62, 8'h62, 8'he1, 8'h53, 8'h53, 8'hff, 8'h43, 8'h43, 8'h63
  };

  typedef struct packed {
    logic [ADDR_W-1:0]  row_address;
    logic [POS_W-1:0]   lane_zero_x;
    logic [3:0][3:0]    colors;
    logic [3:0]         write_mask;
    logic               end_of_sprite;
  } blit_result_t;

  typedef struct {
    bit                 is_write;
    logic [2:0]         reg_idx;
    logic [CFG_W-1:0]   reg_val;
    logic [7:0]         src;
    logic               last;
    bit                 typed;
    blit_result_t       typed_res;
  } stim_row_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cfg_write_en = 1'b0;
  logic [2:0]         cfg_index = '0;
  logic [CFG_W-1:0]   cfg_data = '0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [7:0]         source_byte = '0;
  logic               last_byte = 1'b0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [ADDR_W-1:0]  row_address;
  logic signed [POS_W-1:0] lane_zero_x;
  logic [3:0]         color_lane0;
  logic [3:0]         color_lane1;
  logic [3:0]         color_lane2;
  logic [3:0]         color_lane3;
  logic [3:0]         write_mask;
  logic               end_of_sprite;

  // Predictor copy of the registers and the raster counters.
  int                 cur_dest_x = 0;
  int                 cur_dest_y = 0;
  logic [23:0]        cur_view_base = '0;
  logic [15:0]        cur_stride = '0;
  logic [5:0]         cur_row_bytes = 6'd1;
  logic [4:0]         cur_palette = '0;
  bit                 cur_dither = 1'b0;
  logic [5:0]         column_cnt = '0;
  logic [7:0]         row_cnt = '0;

  blit_result_t       pending_blits[$];
  stim_row_t          directed[$];
  int                 send_idle_pct = 0;
  int                 stall_pct = 0;
  int                 err_count = 0;
  int                 checked_blits = 0;
  int                 sent_items = 0;
  int                 reg_writes = 0;
  int                 idle_cycles = 0;

  sprite_2bpp_palette_blitter i_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_write_en  (cfg_write_en),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .source_byte   (source_byte),
    .last_byte     (last_byte),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .row_address   (row_address),
    .lane_zero_x   (lane_zero_x),
    .color_lane0   (color_lane0),
    .color_lane1   (color_lane1),
    .color_lane2   (color_lane2),
    .color_lane3   (color_lane3),
    .write_mask    (write_mask),
    .end_of_sprite (end_of_sprite)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [3:0] palette_color(logic [4:0] sel, logic [1:0] code);
    logic [7:0] entry;
    logic [3:0] col;
    entry = (sel < 5'd18) ? WALL_COLORS[sel] : WALL_COLORS[0];
    case (code)
      PIX_LOW:   col = entry[3:0];
      PIX_HIGH:  col = entry[7:4];
      PIX_WHITE: col = COLOR_WHITE;
      default:   col = COLOR_CLEAR;
    endcase
    return col;
  endfunction

  task automatic predict_blit(input logic [7:0] src, input logic last,
                              output blit_result_t r);
    int         py;
    int         x0;
    int         px;
    longint     addr;
    logic [5:0] rb;
    logic [3:0] col;
    bit         on;
    py   = cur_dest_y + int'(row_cnt);
    x0   = cur_dest_x + 4 * int'(column_cnt);
    addr = longint'(cur_view_base) + longint'(py) * longint'(cur_stride);
    r.row_address   = addr[ADDR_W-1:0];
    r.lane_zero_x   = x0[POS_W-1:0];
    r.write_mask    = '0;
    r.end_of_sprite = last;
    for (int p = 0; p < 4; p++) begin
      col = palette_color(cur_palette, src[7-2*p -: 2]);
      px  = x0 + p;
      on  = (py >= 0) && (py < VIEW_H) && (col != 4'd0) && (px >= 0) && (px < VIEW_W);
      // Checkerboard dither drops the odd squares.
      if (on && cur_dither && (((px + py) & 1) != 0))
        on = 1'b0;
      r.colors[p]     = col;
      r.write_mask[p] = on;
    end
    rb = (cur_row_bytes == 6'd0) ? 6'd1 : cur_row_bytes;
    if (last) begin
      column_cnt = '0;
      row_cnt    = '0;
    end else if (int'(column_cnt) + 1 >= int'(rb)) begin
      column_cnt = '0;
      row_cnt    = row_cnt + 8'd1;
    end else begin
      column_cnt = column_cnt + 6'd1;
    end
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t: mismatch on %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
    err_count++;
  endtask

  // Called right after a rising edge; returns at the edge that takes the request.
  task automatic send_request(input logic [7:0] b, input logic l, input bit typed,
                              input blit_result_t typed_res);
    blit_result_t predicted;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid    <= 1'b0;
      source_byte <= 8'($urandom_range(0, 255));
      last_byte   <= 1'($urandom_range(0, 1));
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    source_byte <= b;
    last_byte   <= l;
    do @(posedge clk); while (in_stall);
    predict_blit(b, l, predicted);
    pending_blits.push_back(typed ? typed_res : predicted);
    sent_items++;
  endtask

  task automatic drain_pipeline();
    in_valid <= 1'b0;
    while (pending_blits.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [CFG_W-1:0] val);
    cfg_write_en <= 1'b1;
    cfg_index    <= idx;
    cfg_data     <= val;
    @(posedge clk);
    cfg_write_en <= 1'b0;
    @(posedge clk);
    case (idx)
      REG_DEST_X:        cur_dest_x    = int'($signed(val[9:0]));
      REG_DEST_Y:        cur_dest_y    = int'($signed(val[8:0]));
      REG_VIEW_BASE:     cur_view_base = val[23:0];
      REG_LINE_STRIDE:   cur_stride    = val[15:0];
      REG_ROW_BYTES:     cur_row_bytes = val[5:0];
      REG_PALETTE_SEL:   cur_palette   = val[4:0];
      REG_DITHER_ENABLE: cur_dither    = val[0];
      default: ;
    endcase
    reg_writes++;
  endtask

  // Keeps the low w bits and fills the unused upper bits with noise.
  function automatic logic [CFG_W-1:0] pad_junk(logic [CFG_W-1:0] v, int w);
    logic [CFG_W-1:0] junk;
    logic [CFG_W-1:0] keep;
    junk = CFG_W'($urandom);
    keep = (24'd1 << w) - 24'd1;
    return (v & keep) | (junk & ~keep);
  endfunction

  task automatic randomize_config();
    int          dx;
    int          dy;
    int          pick;
    logic [15:0] stride;
    logic [5:0]  rb;
    dx = ($urandom_range(0, 3) == 0) ? ($urandom_range(0, 1) ? 511 : -512)
                                     : int'($urandom_range(0, 260)) - 12;
    dy = ($urandom_range(0, 3) == 0) ? ($urandom_range(0, 1) ? 255 : -256)
                                     : int'($urandom_range(0, 140)) - 6;
    pick = $urandom_range(0, 5);
    stride = (pick == 0) ? 16'd0 : (pick == 1) ? 16'hFFFF : 16'($urandom_range(0, 65535));
    pick = $urandom_range(0, 9);
    if (pick < 7)
      rb = 6'($urandom_range(1, 8));
    else if (pick < 9)
      rb = 6'($urandom_range(9, 63));
    else
      rb = $urandom_range(0, 1) ? 6'd63 : 6'd0;
    write_reg(REG_DEST_X, pad_junk(CFG_W'(dx), 10));
    write_reg(REG_DEST_Y, pad_junk(CFG_W'(dy), 9));
    write_reg(REG_VIEW_BASE, pad_junk(CFG_W'($urandom), 24));
    write_reg(REG_LINE_STRIDE, pad_junk(CFG_W'(stride), 16));
    write_reg(REG_ROW_BYTES, pad_junk(CFG_W'(rb), 6));
    write_reg(REG_PALETTE_SEL, pad_junk(CFG_W'($urandom_range(0, 31)), 5));
    write_reg(REG_DITHER_ENABLE, pad_junk(CFG_W'($urandom_range(0, 1)), 1));
  endtask

  // Mostly whole sprites; some end early or get their row length changed midway.
  task automatic run_sprite();
    int rb;
    int rows;
    int nbytes;
    bit early_last;
    bit regroup;
    rb         = (cur_row_bytes == 6'd0) ? 1 : int'(cur_row_bytes);
    rows       = (rb > 16) ? $urandom_range(1, 2) : $urandom_range(1, 6);
    nbytes     = rows * rb;
    early_last = ($urandom_range(0, 9) == 0);
    regroup    = ($urandom_range(0, 6) == 0);
    for (int k = 0; k < nbytes; k++) begin
      if (regroup && k == nbytes / 2) begin
        drain_pipeline();
        write_reg(REG_ROW_BYTES, pad_junk(CFG_W'($urandom_range(0, 63)), 6));
      end
      send_request(8'($urandom_range(0, 255)),
                   (k == nbytes - 1) || (early_last && $urandom_range(0, 7) == 0),
                   1'b0, '0);
    end
  endtask

  function automatic stim_row_t cfg_row(logic [2:0] idx, logic [CFG_W-1:0] val);
    stim_row_t r;
    r = '{default: '0};
    r.is_write = 1'b1;
    r.reg_idx  = idx;
    r.reg_val  = val;
    return r;
  endfunction

  function automatic stim_row_t item_row(logic [7:0] src, logic last);
    stim_row_t r;
    r = '{default: '0};
    r.src  = src;
    r.last = last;
    return r;
  endfunction

  function automatic stim_row_t typed_row(logic [7:0] src, logic last,
                                          logic [ADDR_W-1:0] addr, logic [POS_W-1:0] x0,
                                          logic [15:0] colors, logic [3:0] mask);
    stim_row_t r;
    r = item_row(src, last);
    r.typed     = 1'b1;
    r.typed_res = '{addr, x0, colors, mask, last};
    return r;
  endfunction

  always @(posedge clk) begin
    out_stall <= ($urandom_range(0, 99) < stall_pct);
  end

  always @(posedge clk) begin
    blit_result_t want;
    blit_result_t got;
    if (!rst && out_valid && !out_stall) begin
      got = '{row_address, lane_zero_x,
              {color_lane3, color_lane2, color_lane1, color_lane0},
              write_mask, end_of_sprite};
      if (pending_blits.size() == 0) begin
        report_mismatch("unexpected result request", 32'(got.row_address), 32'd0);
      end else begin
        want = pending_blits.pop_front();
        checked_blits++;
        if (got.row_address !== want.row_address)
          report_mismatch("row_address", 32'(got.row_address), 32'(want.row_address));
        if (got.lane_zero_x !== want.lane_zero_x)
          report_mismatch("lane_zero_x", 32'(got.lane_zero_x), 32'(want.lane_zero_x));
        for (int p = 0; p < 4; p++) begin
          if (got.colors[p] !== want.colors[p])
            report_mismatch($sformatf("color_lane%0d", p), 32'(got.colors[p]),
                            32'(want.colors[p]));
        end
        if (got.write_mask !== want.write_mask)
          report_mismatch("write_mask", 32'(got.write_mask), 32'(want.write_mask));
        if (got.end_of_sprite !== want.end_of_sprite)
          report_mismatch("end_of_sprite", 32'(got.end_of_sprite), 32'(want.end_of_sprite));
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no request moved for %0d cycles", $time, idle_cycles);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    int mode_start;
    int dy;

    // After reset: palette entry 0, no offset, every row a single byte.
    directed.push_back(typed_row(8'h1B, 1'b0, 25'd0, 11'd0, 16'hFE60, 4'b1110));
    directed.push_back(typed_row(8'hFF, 1'b1, 25'd0, 11'd0, 16'hFFFF, 4'b1111));
    directed.push_back(typed_row(8'h00, 1'b0, 25'd0, 11'd0, 16'h0000, 4'b0000));
    directed.push_back(item_row(8'hE4, 1'b1));
    // Negative extremes: the row lies above the viewport.
    directed.push_back(cfg_row(REG_DEST_X, 24'h000200));
    directed.push_back(cfg_row(REG_DEST_Y, 24'h000100));
    directed.push_back(cfg_row(REG_VIEW_BASE, 24'hFFFFFF));
    directed.push_back(cfg_row(REG_LINE_STRIDE, 24'h00FFFF));
    directed.push_back(cfg_row(REG_ROW_BYTES, 24'd63));
    directed.push_back(cfg_row(REG_PALETTE_SEL, 24'd17));
    directed.push_back(cfg_row(REG_DITHER_ENABLE, 24'd1));
    directed.push_back(typed_row(8'h55, 1'b0, 25'h00000FF, 11'h600, 16'h3333, 4'b0000));
    directed.push_back(item_row(8'h6C, 1'b0));
    directed.push_back(item_row(8'h93, 1'b0));
    // Row length lowered below the current column: the next byte closes the row.
    directed.push_back(cfg_row(REG_ROW_BYTES, 24'd2));
    directed.push_back(item_row(8'h27, 1'b0));
    directed.push_back(item_row(8'hD8, 1'b1));
    // Positive extremes, a wall id past the table, and a row length of zero.
    directed.push_back(cfg_row(REG_DEST_X, 24'h0001FF));
    directed.push_back(cfg_row(REG_DEST_Y, 24'h0000FF));
    directed.push_back(cfg_row(REG_PALETTE_SEL, 24'd31));
    directed.push_back(cfg_row(REG_DITHER_ENABLE, 24'd0));
    directed.push_back(cfg_row(REG_ROW_BYTES, 24'd0));
    directed.push_back(typed_row(8'hAA, 1'b0, 25'h1FEFF00, 11'h1FF, 16'hEEEE, 4'b0000));
    directed.push_back(item_row(8'h3C, 1'b1));
    // Left and bottom viewport edges with dither on.
    directed.push_back(cfg_row(REG_DEST_X, 24'h0003FD));
    directed.push_back(cfg_row(REG_DEST_Y, 24'd130));
    directed.push_back(cfg_row(REG_VIEW_BASE, 24'd100));
    directed.push_back(cfg_row(REG_LINE_STRIDE, 24'd240));
    directed.push_back(cfg_row(REG_DITHER_ENABLE, 24'd1));
    directed.push_back(cfg_row(REG_PALETTE_SEL, 24'd11));
    directed.push_back(item_row(8'hFF, 1'b0));
    directed.push_back(item_row(8'hFF, 1'b0));
    directed.push_back(item_row(8'hFF, 1'b0));
    directed.push_back(item_row(8'h5A, 1'b1));
    // Right viewport edge.
    directed.push_back(cfg_row(REG_DEST_X, 24'd236));
    directed.push_back(cfg_row(REG_DEST_Y, 24'd0));
    directed.push_back(cfg_row(REG_ROW_BYTES, 24'd3));
    directed.push_back(cfg_row(REG_DITHER_ENABLE, 24'd0));
    directed.push_back(cfg_row(REG_PALETTE_SEL, 24'd14));
    directed.push_back(item_row(8'h1B, 1'b0));
    directed.push_back(item_row(8'hE4, 1'b0));
    directed.push_back(item_row(8'hFF, 1'b1));
    directed.push_back(cfg_row(REG_SPARE, 24'hABCDEF));
    directed.push_back(item_row(8'h99, 1'b1));

    send_idle_pct = 32;
    stall_pct     = 60;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed[i]) begin
      if (directed[i].is_write) begin
        drain_pipeline();
        write_reg(directed[i].reg_idx, directed[i].reg_val);
      end else begin
        send_request(directed[i].src, directed[i].last, directed[i].typed,
                     directed[i].typed_res);
      end
    end

    for (int mode = 0; mode < 3; mode++) begin
      send_idle_pct = (mode == 0) ? 32 : (mode == 1) ? 60 : 0;
      stall_pct     = (mode == 0) ? 60 : (mode == 1) ? 32 : 0;
      mode_start    = sent_items;
      if (mode == 2) begin
        // One long sprite of single-byte rows runs the row counter past 255.
        drain_pipeline();
        dy = -100;
        write_reg(REG_ROW_BYTES, pad_junk(24'd1, 6));
        write_reg(REG_DEST_Y, pad_junk(CFG_W'(dy), 9));
        for (int k = 0; k < 300; k++)
          send_request(8'($urandom_range(0, 255)), k == 299, 1'b0, '0);
      end
      while (sent_items - mode_start < ITEMS_PER_MODE) begin
        drain_pipeline();
        randomize_config();
        run_sprite();
      end
    end

    drain_pipeline();
    $display("Checked %0d blit results from %0d source bytes across %0d register writes,",
             checked_blits, sent_items, reg_writes);
    $display("with sender and receiver idling in turn and then at full rate.");
    if (err_count == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule

// ===== sprite_2bpp_palette_blitter.f =====
+incdir+sv
sv/spb_pkg.sv
sv/spb_lane.sv
sv/spb_ctrl.sv
sv/sprite_2bpp_palette_blitter.sv
sv/spb_checker.sv
sim/testbench.sv
